>>> src/median_filter_2d_core_assert.svh
// Assertion macros for the median filter core checker.
`ifndef MEDIAN_FILTER_2D_CORE_ASSERT_SVH
`define MEDIAN_FILTER_2D_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is low.
`define MF2D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MF2D_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/mf2d_pkg.sv
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared constants, payload types and queue entry type of the median filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

  localparam int RADIUS     = 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int WIN_SIDE = 2 * RADIUS + 1;
  localparam int WIN_N    = WIN_SIDE * WIN_SIDE;
  localparam int N_LINES  = 2 * RADIUS;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int IROW_W  = $clog2(MAX_HEIGHT + RADIUS + 1);
  localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int LAG_MAX = RADIUS * MAX_WIDTH + RADIUS;
  localparam int LAG_W   = $clog2(LAG_MAX + 1);

  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] median_value;
    logic             frame_last;
  } pix_out_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [PIX_W-1:0]    value;
    logic [COL_W-1:0]    col;
    logic                emit;
    logic                last;
    logic [WIN_SIDE-1:0] row_ok;
    logic [WIN_SIDE-1:0] col_ok;
  } fe_item_t;

endpackage

>>> src/median_filter_2d_core.sv
// ----------------------------------------------------------------------------
// median_filter_2d_core
// Streaming 2-D median filter over a zero-padded square window.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | pixel, flush
//   out     | output    | out_valid/out_ready| median_value, frame_last
//   cfg     | input     | cfg_we             | cfg_idx, cfg_wdata
//
// One item per cycle sustained while the output is taken; the line store RAMs
// take one read and one write a cycle and the rank pipeline starts a window
// every cycle. A result passes stage A, the window, stage D and the output
// register after its last window item leaves the queue; results lag inputs by
// RADIUS*W+RADIUS items. No clearing pass after reset: entries that were never
// written are always masked by the border flags. An output stall holds the back
// pipeline; the four-entry queue keeps the input open meanwhile.
module median_filter_2d_core import mf2d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_data_o
);

  logic     q_ready;
  logic     push;
  fe_item_t push_item;
  logic     q_valid;
  fe_item_t q_item;
  logic     pop;

  mf2d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .item_o     (push_item)
  );

  mf2d_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .ready_o(q_ready),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  mf2d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .item_i     (q_item),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> src/mf2d_ram.sv
// ----------------------------------------------------------------------------
// mf2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mf2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mf2d_front.sv
// ----------------------------------------------------------------------------
// mf2d_front
// Accepts pixel items, tracks frame position, drops early flush items and
// tags each kept item with output, border and end-of-frame information.
// ----------------------------------------------------------------------------
module mf2d_front import mf2d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  input  logic                  q_ready_i,
  output logic                  push_o,
  output fe_item_t              item_o
);

  logic [CFG_WIDTH_W-1:0]  cfg_w_q;
  logic [CFG_HEIGHT_W-1:0] cfg_h_q;
  logic [WDIM_W-1:0]       cur_w_q;
  logic [HDIM_W-1:0]       cur_h_q;
  logic [LAG_W-1:0]        lag_q;
  logic                    start_q;
  logic [COL_W-1:0]        in_col_q;
  logic [IROW_W-1:0]       in_row_q;
  logic [COL_W-1:0]        out_col_q;
  logic [ROW_W-1:0]        out_row_q;
  logic [LAG_W-1:0]        fill_q;

  logic [WDIM_W-1:0] w_clamp;
  logic [HDIM_W-1:0] h_clamp;
  logic [LAG_W-1:0]  lag_clamp;
  logic [WDIM_W-1:0] w_eff;
  logic [HDIM_W-1:0] h_eff;
  logic              acc;
  logic              real_pix;
  logic              drop;
  logic              emit;
  logic              last;
  logic              in_col_end;
  logic              out_col_end;
  logic [WIN_SIDE-1:0] row_ok;
  logic [WIN_SIDE-1:0] col_ok;

  // clamp the configured frame size
  always_comb begin
    if (cfg_w_q == '0) begin
      w_clamp = WDIM_W'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w_clamp = WDIM_W'(MAX_WIDTH);
    end else begin
      w_clamp = WDIM_W'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_clamp = HDIM_W'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      h_clamp = HDIM_W'(MAX_HEIGHT);
    end else begin
      h_clamp = HDIM_W'(cfg_h_q);
    end
  end

  assign lag_clamp = LAG_W'(RADIUS * int'(w_clamp) + RADIUS);

  // size in force for this item: fresh at frame start
  assign w_eff = start_q ? w_clamp : cur_w_q;
  assign h_eff = start_q ? h_clamp : cur_h_q;

  assign acc         = in_valid_i && q_ready_i;
  assign real_pix    = 32'(in_row_q) < 32'(h_eff);
  assign drop        = real_pix && in_data_i.flush;
  assign emit        = !start_q && (fill_q == lag_q);
  assign in_col_end  = 32'(in_col_q) == 32'(w_eff) - 32'd1;
  assign out_col_end = 32'(out_col_q) == 32'(w_eff) - 32'd1;
  assign last        = emit && out_col_end && (32'(out_row_q) == 32'(h_eff) - 32'd1);

  // border flags of the window around the output pixel
  always_comb begin
    int rr;
    int cc;
    for (int k = 0; k < WIN_SIDE; k++) begin
      rr = int'(out_row_q) + k - RADIUS;
      cc = int'(out_col_q) + k - RADIUS;
      row_ok[k] = (rr >= 0) && (rr < int'(h_eff));
      col_ok[k] = (cc >= 0) && (cc < int'(w_eff));
    end
  end

  // build the queue entry
  always_comb begin
    item_o.value  = real_pix ? in_data_i.pixel : '0;
    item_o.col    = in_col_q;
    item_o.emit   = emit;
    item_o.last   = last;
    item_o.row_ok = row_ok;
    item_o.col_ok = col_ok;
  end

  assign push_o     = acc && !drop;
  assign in_ready_o = q_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_WIDTH_W'(1024);
      cfg_h_q <= CFG_HEIGHT_W'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  cfg_w_q <= cfg_wdata_i[CFG_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: cfg_h_q <= cfg_wdata_i[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // frame position tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_w_q   <= WDIM_W'(1024);
      cur_h_q   <= HDIM_W'(1024);
      lag_q     <= '0;
      start_q   <= 1'b1;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q    <= '0;
    end else if (acc) begin
      if (start_q) begin
        cur_w_q <= w_clamp;
        cur_h_q <= h_clamp;
        lag_q   <= lag_clamp;
      end
      if (!drop) begin
        if (last) begin
          start_q   <= 1'b1;
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          fill_q    <= '0;
        end else begin
          start_q <= 1'b0;
          if (in_col_end) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + 1'b1;
          end else begin
            in_col_q <= in_col_q + 1'b1;
          end
          if (emit) begin
            if (out_col_end) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + 1'b1;
            end else begin
              out_col_q <= out_col_q + 1'b1;
            end
          end else begin
            fill_q <= fill_q + 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> src/mf2d_fifo.sv
// ----------------------------------------------------------------------------
// mf2d_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module mf2d_fifo import mf2d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fe_item_t item_i,
  output logic     ready_o,
  input  logic     pop_i,
  output logic     valid_o,
  output fe_item_t item_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  fe_item_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q;
  logic [PTR_W-1:0] rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign ready_o = 32'(count_q) < FIFO_DEPTH;
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (32'(wptr_q) == FIFO_DEPTH - 1) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (32'(rptr_q) == FIFO_DEPTH - 1) ? '0 : rptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> src/mf2d_back.sv
// ----------------------------------------------------------------------------
// mf2d_back
// Line stores, window registers and a rank-based median pipeline.
// ----------------------------------------------------------------------------
module mf2d_back import mf2d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  fe_item_t item_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t out_data_o
);

  localparam int MED_RANK = WIN_N / 2;

  logic     en;
  logic     a_valid_q;
  fe_item_t a_item_q;

  logic [PIX_W-1:0] ram_rd     [N_LINES];
  logic [PIX_W-1:0] line_rd    [N_LINES];
  logic [PIX_W-1:0] wr_data    [N_LINES];
  logic [PIX_W-1:0] fwd_data_q [N_LINES];
  logic             fwd_q;
  logic [PIX_W-1:0] colvec     [WIN_SIDE];

  logic [PIX_W-1:0]    win_q [WIN_SIDE][WIN_SIDE];
  logic                c_valid_q;
  logic                c_last_q;
  logic [WIN_SIDE-1:0] c_row_ok_q;
  logic [WIN_SIDE-1:0] c_col_ok_q;

  logic [PIX_W-1:0] val   [WIN_N];
  logic [WIN_N-1:0] bef   [WIN_N];
  logic             d_valid_q;
  logic             d_last_q;
  logic [PIX_W-1:0] d_val_q [WIN_N];
  logic [WIN_N-1:0] d_bef_q [WIN_N];

  logic [PIX_W-1:0] med;
  logic             out_valid_q;
  pix_out_t         out_data_q;

  // whole pipeline moves when the output slot is free or taken
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && valid_i;

  // stage A: item with its line reads in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (en) begin
      a_valid_q <= valid_i;
      fwd_q     <= a_valid_q && valid_i && (item_i.col == a_item_q.col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_item_q <= item_i;
      for (int g = 0; g < N_LINES; g++) begin
        fwd_data_q[g] <= wr_data[g];
      end
    end
  end

  // line stores: each shifts a row down at the item's column
  for (genvar g = 0; g < N_LINES; g++) begin : g_line
    mf2d_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk_i  (clk_i),
      .we_i   (en && a_valid_q),
      .waddr_i(a_item_q.col),
      .wdata_i(wr_data[g]),
      .re_i   (en),
      .raddr_i(item_i.col),
      .rdata_o(ram_rd[g])
    );
  end

  // forward the write of the previous item when it hit the same column
  always_comb begin
    for (int g = 0; g < N_LINES; g++) begin
      line_rd[g] = fwd_q ? fwd_data_q[g] : ram_rd[g];
    end
    wr_data[0] = a_item_q.value;
    for (int g = 1; g < N_LINES; g++) begin
      wr_data[g] = line_rd[g-1];
    end
    colvec[0] = a_item_q.value;
    for (int g = 0; g < N_LINES; g++) begin
      colvec[g+1] = line_rd[g];
    end
  end

  // window: shift in the newest column
  always_ff @(posedge clk_i) begin
    if (en && a_valid_q) begin
      for (int e = 0; e < WIN_SIDE; e++) begin
        win_q[0][e] <= colvec[e];
      end
      for (int c = 1; c < WIN_SIDE; c++) begin
        for (int e = 0; e < WIN_SIDE; e++) begin
          win_q[c][e] <= win_q[c-1][e];
        end
      end
      c_last_q   <= a_item_q.last;
      c_row_ok_q <= a_item_q.row_ok;
      c_col_ok_q <= a_item_q.col_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= a_valid_q && a_item_q.emit;
    end
  end

  // zero padding, then pairwise ordering with ties broken by position
  always_comb begin
    for (int ii = 0; ii < WIN_SIDE; ii++) begin
      for (int jj = 0; jj < WIN_SIDE; jj++) begin
        val[ii*WIN_SIDE+jj] = (c_row_ok_q[ii] && c_col_ok_q[jj]) ?
                              win_q[WIN_SIDE-1-jj][WIN_SIDE-1-ii] : '0;
      end
    end
    for (int k = 0; k < WIN_N; k++) begin
      for (int m = 0; m < WIN_N; m++) begin
        bef[k][m] = (val[m] < val[k]) || ((val[m] == val[k]) && (m < k));
      end
    end
  end

  // stage D: register comparisons
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_last_q <= c_last_q;
      for (int k = 0; k < WIN_N; k++) begin
        d_val_q[k] <= val[k];
        d_bef_q[k] <= bef[k];
      end
    end
  end

  // pick the element whose rank is the middle one
  always_comb begin
    med = '0;
    for (int k = 0; k < WIN_N; k++) begin
      if ($countones(d_bef_q[k]) == MED_RANK) begin
        med = med | d_val_q[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.median_value <= med;
      out_data_q.frame_last   <= d_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> src/mf2d_checker.sv
// ----------------------------------------------------------------------------
// mf2d_checker
// Port-level checks of the median filter core, bound to the top level.
// ----------------------------------------------------------------------------
`include "median_filter_2d_core_assert.svh"

module mf2d_checker import mf2d_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input pix_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pix_out_t out_data_o
);

  // hold a stalled result
  `MF2D_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // hold a waiting input item
  `MF2D_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i), "waiting item changed")

  // a cycle with a free output slot drains the queue enough to take an item
  `MF2D_ASSERT(a_ready_after_free, $past(!out_valid_o) |-> in_ready_o, "input blocked after free output")

  // no result once reset has been seen
  `MF2D_ASSERT_NR(a_reset_quiet, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule

bind median_filter_2d_core mf2d_checker u_checker (.*);
